[hdl/slt_pkg.sv]
// Shared types, constants and character classes for the small language tokenizer.
package slt_pkg;

	// Width of the running source position (saturates at all ones)
	localparam int POS_BITS = 16;
	localparam int OUT_BITS = 16;
	localparam int KIND_BITS = 4;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS = $clog2(QUEUE_DEPTH);

	localparam logic [POS_BITS-1:0] POS_MAX = '1;

	// Token kinds
	localparam logic [KIND_BITS-1:0] K_IDENT  = 4'd0;
	localparam logic [KIND_BITS-1:0] K_INT    = 4'd1;
	localparam logic [KIND_BITS-1:0] K_EQUALS = 4'd2;
	localparam logic [KIND_BITS-1:0] K_ARROW  = 4'd3;
	localparam logic [KIND_BITS-1:0] K_LPAREN = 4'd4;
	localparam logic [KIND_BITS-1:0] K_RPAREN = 4'd5;
	localparam logic [KIND_BITS-1:0] K_LBRACE = 4'd6;
	localparam logic [KIND_BITS-1:0] K_RBRACE = 4'd7;
	localparam logic [KIND_BITS-1:0] K_COLON  = 4'd8;
	localparam logic [KIND_BITS-1:0] K_COMMA  = 4'd9;
	localparam logic [KIND_BITS-1:0] K_LT     = 4'd10;
	localparam logic [KIND_BITS-1:0] K_GT     = 4'd11;
	localparam logic [KIND_BITS-1:0] K_SEMI   = 4'd12;
	localparam logic [KIND_BITS-1:0] K_EOF    = 4'd13;
	localparam logic [KIND_BITS-1:0] K_ERROR  = 4'd14;

	// Characters with a meaning of their own
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_GT    = 8'h3E;

	typedef enum logic [2:0] {
		MODE_IDLE,
		MODE_IDENT,
		MODE_INT,
		MODE_EQ,
		MODE_HALT
	} scan_mode_t;

	typedef struct packed {
		logic [KIND_BITS-1:0] kind;
		logic [OUT_BITS-1:0]  start;
		logic [OUT_BITS-1:0]  len;
	} tok_t;

	// One queue entry: all tokens caused by one source byte
	typedef struct packed {
		tok_t tok0;
		tok_t tok1;
		logic two;
	} qent_t;

	function automatic logic is_letter(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic logic is_sep(input logic [7:0] c);
		return c == CH_CR || c == CH_LF || c == CH_SPACE || c == CH_TAB;
	endfunction

	// Punctuation kind; valid flag returned in bit KIND_BITS
	function automatic logic [KIND_BITS:0] punct_kind(input logic [7:0] c);
		logic [KIND_BITS:0] r;
		case (c)
			8'h28: r = {1'b1, K_LPAREN};
			8'h29: r = {1'b1, K_RPAREN};
			8'h7B: r = {1'b1, K_LBRACE};
			8'h7D: r = {1'b1, K_RBRACE};
			8'h3A: r = {1'b1, K_COLON};
			8'h2C: r = {1'b1, K_COMMA};
			8'h3C: r = {1'b1, K_LT};
			8'h3E: r = {1'b1, K_GT};
			8'h3B: r = {1'b1, K_SEMI};
			default: r = '0;
		endcase
		return r;
	endfunction

	// Clip a position or length to the output field width
	function automatic logic [OUT_BITS-1:0] clip_out(input logic [32:0] v);
		logic [32:0] lim;
		lim = 33'({OUT_BITS{1'b1}});
		return (v > lim) ? {OUT_BITS{1'b1}} : v[OUT_BITS-1:0];
	endfunction

endpackage

[hdl/small_language_tokenizer_core.sv]
// Top level of the small language tokenizer: front end, queue and token output stage.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+-------------------------------------------
//   source  | in        | ch_valid / ch_stall | ch[7:0]
//   token   | out       | tok_valid/tok_stall | kind, start_offset, token_length, last
//
// One source byte is taken per cycle while ch_stall is low; it is classified in the cycle it is accepted.
// A byte that closes a token and makes one of its own yields two tokens, sent
// one after the other by the output stage; the four-entry queue absorbs such bursts.
// A token passes through the queue and then the output register. Reset clears scan state and queue.
// ch_stall rises only while the queue is full; tok_stall holds the output register.
module small_language_tokenizer_core import slt_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 ch_valid,
	output logic                 ch_stall,
	input  logic [7:0]           ch,
	output logic                 tok_valid,
	input  logic                 tok_stall,
	output logic [KIND_BITS-1:0] kind,
	output logic [OUT_BITS-1:0]  start_offset,
	output logic [OUT_BITS-1:0]  token_length,
	output logic                 last
);

	logic  q_full, q_push, q_pop, q_nonempty;
	qent_t q_wr, q_rd;

	slt_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.ch_valid (ch_valid),
		.ch_stall (ch_stall),
		.ch       (ch),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_entry  (q_wr)
	);

	slt_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.wr_entry (q_wr),
		.full     (q_full),
		.pop      (q_pop),
		.nonempty (q_nonempty),
		.rd_entry (q_rd)
	);

	slt_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_nonempty   (q_nonempty),
		.q_entry      (q_rd),
		.q_pop        (q_pop),
		.tok_valid    (tok_valid),
		.tok_stall    (tok_stall),
		.kind         (kind),
		.start_offset (start_offset),
		.token_length (token_length),
		.last         (last)
	);

endmodule

[hdl/slt_front.sv]
// Front end: accepts source bytes, tracks scan state and forms the tokens of each byte.
module slt_front import slt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        ch_valid,
	output logic        ch_stall,
	input  logic [7:0]  ch,
	input  logic        q_full,
	output logic        q_push,
	output qent_t       q_entry
);

	scan_mode_t            mode_q, mode_d;
	logic [POS_BITS-1:0]   pos_q, pos_d;
	logic [POS_BITS-1:0]   ts_q, ts_d;
	logic                  accept;
	logic                  close_v, fresh_v, restart, cont;
	tok_t                  close_tok, fresh_tok;
	logic [POS_BITS:0]     span;
	logic [KIND_BITS:0]    pk;

	assign ch_stall = q_full;
	assign accept = ch_valid && !ch_stall;

	// Classify the byte against the open token
	always_comb begin
		mode_d = mode_q;
		ts_d = ts_q;
		pos_d = pos_q;
		close_v = 1'b0;
		fresh_v = 1'b0;
		restart = 1'b0;
		cont = 1'b0;
		close_tok = '0;
		fresh_tok = '0;
		span = {1'b0, pos_q} - {1'b0, ts_q};
		pk = punct_kind(ch);

		case (mode_q)
			MODE_IDENT: begin
				if (is_letter(ch)) begin
					cont = 1'b1;
				end else begin
					close_v = 1'b1;
					close_tok = '{K_IDENT, clip_out(33'(ts_q)), clip_out(33'(span))};
				end
			end
			MODE_INT: begin
				if (is_digit(ch)) begin
					cont = 1'b1;
				end else begin
					close_v = 1'b1;
					close_tok = '{K_INT, clip_out(33'(ts_q)), clip_out(33'(span))};
				end
			end
			MODE_EQ: begin
				close_v = 1'b1;
				if (ch == CH_GT) begin
					cont = 1'b1;
					mode_d = MODE_IDLE;
					close_tok = '{K_ARROW, clip_out(33'(ts_q)),
						clip_out(33'(span) + 33'd1)};
				end else begin
					close_tok = '{K_EQUALS, clip_out(33'(ts_q)), clip_out(33'(span))};
				end
			end
			default: ;
		endcase

		// Handle the byte with no token open
		if (mode_q != MODE_HALT && !cont) begin
			mode_d = MODE_IDLE;
			if (is_sep(ch)) begin
				mode_d = MODE_IDLE;
			end else if (is_letter(ch)) begin
				mode_d = MODE_IDENT;
				ts_d = pos_q;
			end else if (is_digit(ch)) begin
				mode_d = MODE_INT;
				ts_d = pos_q;
			end else if (ch == CH_EQ) begin
				mode_d = MODE_EQ;
				ts_d = pos_q;
			end else if (pk[KIND_BITS]) begin
				fresh_v = 1'b1;
				fresh_tok = '{pk[KIND_BITS-1:0], clip_out(33'(pos_q)), 16'd1};
			end else if (ch == CH_NUL) begin
				fresh_v = 1'b1;
				fresh_tok = '{K_EOF, clip_out(33'(pos_q)), 16'd0};
				restart = 1'b1;
			end else begin
				fresh_v = 1'b1;
				fresh_tok = '{K_ERROR, clip_out(33'(pos_q)), 16'd1};
				mode_d = MODE_HALT;
			end
		end

		// Position advance, saturating; a NUL byte restarts the position at zero
		if (restart) begin
			pos_d = '0;
			ts_d = '0;
		end else if (mode_d != MODE_HALT && mode_q != MODE_HALT && pos_q != POS_MAX) begin
			pos_d = pos_q + 1'b1;
		end
	end

	// Queue entry: closing token first, then the byte's own token
	always_comb begin
		q_entry.two = close_v && fresh_v;
		q_entry.tok0 = close_v ? close_tok : fresh_tok;
		q_entry.tok1 = fresh_tok;
		q_push = accept && (close_v || fresh_v);
	end

	// Scan state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			pos_q <= '0;
			ts_q <= '0;
		end else if (accept) begin
			mode_q <= mode_d;
			pos_q <= pos_d;
			ts_q <= ts_d;
		end
	end

endmodule

[hdl/slt_queue.sv]
// Short queue between the front end and the token output stage.
module slt_queue import slt_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  qent_t wr_entry,
	output logic  full,
	input  logic  pop,
	output logic  nonempty,
	output qent_t rd_entry
);

	qent_t                 mem [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0]  wr_ptr_q, rd_ptr_q;
	logic [QPTR_BITS:0]    count_q;
	logic                  do_push, do_pop;

	assign full = count_q == (QPTR_BITS+1)'(QUEUE_DEPTH);
	assign nonempty = count_q != '0;
	assign rd_entry = mem[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop = pop && nonempty;

	// Entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= wr_entry;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[hdl/slt_back.sv]
// Back end: unpacks queue entries into single tokens behind an output register.
module slt_back import slt_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_nonempty,
	input  qent_t                q_entry,
	output logic                 q_pop,
	output logic                 tok_valid,
	input  logic                 tok_stall,
	output logic [KIND_BITS-1:0] kind,
	output logic [OUT_BITS-1:0]  start_offset,
	output logic [OUT_BITS-1:0]  token_length,
	output logic                 last
);

	logic  out_v_q;
	tok_t  out_tok_q;
	logic  out_last_q;
	logic  hold_v_q;
	tok_t  hold_tok_q;
	logic  load;

	// Output register may take a new token when empty or being taken
	assign load = !out_v_q || !tok_stall;
	assign q_pop = load && !hold_v_q && q_nonempty;

	assign tok_valid = out_v_q;
	assign kind = out_tok_q.kind;
	assign start_offset = out_tok_q.start;
	assign token_length = out_tok_q.len;
	assign last = out_last_q;

	// Output valid and second-token hold flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			hold_v_q <= 1'b0;
		end else if (load) begin
			if (hold_v_q) begin
				out_v_q <= 1'b1;
				hold_v_q <= 1'b0;
			end else begin
				out_v_q <= q_nonempty;
				hold_v_q <= q_nonempty && q_entry.two;
			end
		end
	end

	// Token payload
	always_ff @(posedge clk) begin
		if (load) begin
			if (hold_v_q) begin
				out_tok_q <= hold_tok_q;
				out_last_q <= 1'b1;
			end else begin
				out_tok_q <= q_entry.tok0;
				out_last_q <= !q_entry.two;
				hold_tok_q <= q_entry.tok1;
			end
		end
	end

endmodule

[tb/tb_small_language_tokenizer_core.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the small language tokenizer core with a token scoreboard.
module tb_small_language_tokenizer_core;
	import slt_pkg::*;

	localparam int CLK_PERIOD     = 2;
	localparam int RESET_CYCLES   = 5;
	localparam int MAX_GAP        = 18;
	localparam int RANDOM_BYTES   = 1280;
	localparam int BURST_BYTES    = 40;
	localparam int LONG_HOLD      = 300;
	localparam int LONG_IDENT_LEN = 60;
	localparam int DRAIN_LIMIT    = 5000;
	localparam int SETTLE         = 20;
	localparam int CYCLE_LIMIT    = 1000000;

	localparam int unsigned OUT_LIM = (1 << OUT_BITS) - 1;

	localparam logic [7:0] CH_LOWER_A = "a";
	localparam logic [7:0] CH_UPPER_A = "A";
	localparam logic [7:0] CH_ZERO    = "0";
	localparam logic [7:0] CH_BAD     = 8'hFF;

	localparam logic [8*9-1:0]  PUNCT   = "(){}:,<>;";
	localparam logic [8*4-1:0]  BLANKS  = {CH_TAB, CH_LF, CH_CR, CH_SPACE};
	localparam logic [8*19-1:0] OPENING = "aZ=>09==zA(){}:,<>;";
	localparam logic [8*7-1:0]  TAIL    = "(=>12 =";

	typedef struct {
		logic [KIND_BITS-1:0] kind;
		logic [OUT_BITS-1:0]  start;
		logic [OUT_BITS-1:0]  len;
		logic                 last;
	} token_t;

	// Scanner model plus the queue of tokens still owed by the block
	class token_scoreboard;
		scan_mode_t          mode      = MODE_IDLE;
		logic [POS_BITS-1:0] pos       = '0;
		logic [POS_BITS-1:0] tok_start = '0;
		token_t              expected_tokens[$];
		int                  bytes_in   = 0;
		int                  tokens_out = 0;
		int                  mismatches = 0;
		logic [14:0]         kinds_seen = '0;

		static function bit is_alpha(input logic [7:0] c);
			return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
		endfunction

		static function bit is_num(input logic [7:0] c);
			return c >= "0" && c <= "9";
		endfunction

		static function bit is_blank(input logic [7:0] c);
			return c == CH_CR || c == CH_LF || c == CH_SPACE || c == CH_TAB;
		endfunction

		static function bit punct_token(input logic [7:0] c, output logic [KIND_BITS-1:0] k);
			k = K_ERROR;
			case (c)
				"(": k = K_LPAREN;
				")": k = K_RPAREN;
				"{": k = K_LBRACE;
				"}": k = K_RBRACE;
				":": k = K_COLON;
				",": k = K_COMMA;
				"<": k = K_LT;
				">": k = K_GT;
				";": k = K_SEMI;
				default: return 1'b0;
			endcase
			return 1'b1;
		endfunction

		// True for every byte that does not halt the scanner
		static function bit is_legal(input logic [7:0] c);
			logic [KIND_BITS-1:0] k;
			return is_alpha(c) || is_num(c) || is_blank(c) || c == CH_EQ || c == CH_NUL
				|| punct_token(c, k);
		endfunction

		function void add_token(input logic [KIND_BITS-1:0] k, input int unsigned from,
				input int unsigned span);
			token_t t;
			t.kind  = k;
			t.start = (from > OUT_LIM) ? '1 : OUT_BITS'(from);
			t.len   = (span > OUT_LIM) ? '1 : OUT_BITS'(span);
			t.last  = 1'b0;
			expected_tokens.push_back(t);
		endfunction

		// Accepted source byte: advance the scanner and queue the tokens it causes
		function void note_byte(input logic [7:0] c);
			logic [POS_BITS-1:0]  p;
			logic [KIND_BITS-1:0] pk;
			int                   queued;
			bit                   consumed;
			bit                   restart;
			p        = pos;
			queued   = expected_tokens.size();
			consumed = 1'b0;
			restart  = 1'b0;
			bytes_in++;
			if (mode == MODE_HALT)
				return;

			// extend or close the open token
			case (mode)
				MODE_IDENT: begin
					if (is_alpha(c))
						consumed = 1'b1;
					else begin
						add_token(K_IDENT, tok_start, p - tok_start);
						mode = MODE_IDLE;
					end
				end
				MODE_INT: begin
					if (is_num(c))
						consumed = 1'b1;
					else begin
						add_token(K_INT, tok_start, p - tok_start);
						mode = MODE_IDLE;
					end
				end
				MODE_EQ: begin
					mode = MODE_IDLE;
					if (c == CH_GT) begin
						add_token(K_ARROW, tok_start, p - tok_start + 1);
						consumed = 1'b1;
					end else
						add_token(K_EQUALS, tok_start, p - tok_start);
				end
				default: mode = MODE_IDLE;
			endcase

			// byte seen with no token open
			if (!consumed) begin
				if (is_alpha(c)) begin
					mode      = MODE_IDENT;
					tok_start = p;
				end else if (is_num(c)) begin
					mode      = MODE_INT;
					tok_start = p;
				end else if (c == CH_EQ) begin
					mode      = MODE_EQ;
					tok_start = p;
				end else if (punct_token(c, pk))
					add_token(pk, p, 1);
				else if (c == CH_NUL) begin
					add_token(K_EOF, p, 0);
					restart = 1'b1;
				end else if (!is_blank(c)) begin
					add_token(K_ERROR, p, 1);
					mode = MODE_HALT;
				end
			end

			if (restart) begin
				pos       = '0;
				tok_start = '0;
			end else if (mode != MODE_HALT && pos != POS_MAX)
				pos = pos + 1'b1;
			if (expected_tokens.size() > queued)
				expected_tokens[expected_tokens.size() - 1].last = 1'b1;
		endfunction

		// Accepted token: compare against the oldest one owed
		function void check_token(input logic [KIND_BITS-1:0] k, input logic [OUT_BITS-1:0] s,
				input logic [OUT_BITS-1:0] l, input logic lst);
			token_t t;
			tokens_out++;
			if (expected_tokens.size() == 0) begin
				$error("token with none pending: kind %0d start %0d length %0d", k, s, l);
				mismatches++;
				return;
			end
			t = expected_tokens.pop_front();
			kinds_seen[t.kind] = 1'b1;
			if (k !== t.kind) begin
				$error("kind: expected %0d, got %0d", t.kind, k);
				mismatches++;
			end
			if (s !== t.start) begin
				$error("start_offset: expected %0d, got %0d", t.start, s);
				mismatches++;
			end
			if (l !== t.len) begin
				$error("token_length: expected %0d, got %0d", t.len, l);
				mismatches++;
			end
			if (lst !== t.last) begin
				$error("last: expected %0d, got %0d", t.last, lst);
				mismatches++;
			end
		endfunction

		function int outstanding();
			return expected_tokens.size();
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 ch_valid;
	logic                 ch_stall;
	logic [7:0]           ch;
	logic                 tok_valid;
	logic                 tok_stall;
	logic [KIND_BITS-1:0] kind;
	logic [OUT_BITS-1:0]  start_offset;
	logic [OUT_BITS-1:0]  token_length;
	logic                 last;

	token_scoreboard sb;
	bit              sender_gaps = 1'b1;
	int              long_hold   = 0;
	int              cycles      = 0;

	small_language_tokenizer_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.ch_valid     (ch_valid),
		.ch_stall     (ch_stall),
		.ch           (ch),
		.tok_valid    (tok_valid),
		.tok_stall    (tok_stall),
		.kind         (kind),
		.start_offset (start_offset),
		.token_length (token_length),
		.last         (last)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Offer one source byte; returns once the transaction is taken
	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = sender_gaps ? $urandom_range(0, MAX_GAP) : 0;
		if (gap > 0) begin
			ch_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		ch_valid <= 1'b1;
		ch       <= b;
		do @(posedge clk); while (ch_stall);
		sb.note_byte(b);
	endtask

	// Stop offering and wait for every owed token
	task automatic drain_tokens();
		ch_valid <= 1'b0;
		do @(posedge clk); while (sb.outstanding() != 0);
	endtask

	// Mostly well-formed lexemes with random content, some random legal bytes
	task automatic send_random_piece();
		int         r;
		int         n;
		logic [7:0] b;
		r = $urandom_range(0, 99);
		if (r < 25) begin
			n = ($urandom_range(0, 15) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
			repeat (n) begin
				b = ($urandom_range(0, 1) != 0) ? CH_LOWER_A : CH_UPPER_A;
				send_byte(b + 8'($urandom_range(0, 25)));
			end
		end else if (r < 43) begin
			n = $urandom_range(1, 6);
			repeat (n) send_byte(CH_ZERO + 8'($urandom_range(0, 9)));
		end else if (r < 53) begin
			send_byte(CH_EQ);
			if ($urandom_range(0, 1) != 0)
				send_byte(CH_GT);
		end else if (r < 72)
			send_byte(PUNCT[8 * $urandom_range(0, 8) +: 8]);
		else if (r < 88)
			send_byte(BLANKS[8 * $urandom_range(0, 3) +: 8]);
		else if (r < 92)
			send_byte(CH_NUL);
		else begin
			do b = 8'($urandom_range(0, 255)); while (!token_scoreboard::is_legal(b));
			send_byte(b);
		end
	endtask

	// Run guard
	initial begin : watchdog
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Token sink: random hold-off per transaction, long hold on request
	initial begin : token_sink
		int hold;
		bit sink_gaps;
		sink_gaps = 1'b1;
		@(posedge arst_n);
		forever begin
			if (long_hold > 0) begin
				hold      = long_hold;
				long_hold = 0;
			end else
				hold = sink_gaps ? $urandom_range(0, MAX_GAP) : 0;
			if ($urandom_range(0, 49) == 0)
				sink_gaps = !sink_gaps;
			if (hold > 0) begin
				tok_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			tok_stall <= 1'b0;
			do @(posedge clk); while (!tok_valid);
			sb.check_token(kind, start_offset, token_length, last);
		end
	end

	initial begin : stimulus
		int random_goal;
		int wait_cycles;
		sb        = new;
		arst_n    = 1'b0;
		ch_valid  = 1'b0;
		ch        = '0;
		tok_stall = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// directed: boundary letters and digits, every kind but error, two-token bytes, eof twice
		for (int i = 18; i >= 0; i--)
			send_byte(OPENING[8 * i +: 8]);
		for (int i = 3; i >= 0; i--)
			send_byte(BLANKS[8 * i +: 8]);
		send_byte(CH_ZERO + 8'd7);
		send_byte(CH_NUL);
		send_byte(CH_NUL);

		// sender waits for all tokens before going on
		drain_tokens();

		// sink holds off while punctuation streams in at full rate
		long_hold   = LONG_HOLD;
		sender_gaps = 1'b0;
		repeat (BURST_BYTES) send_byte(PUNCT[8 * $urandom_range(0, 8) +: 8]);
		sender_gaps = 1'b1;

		// random source text
		random_goal = sb.bytes_in + RANDOM_BYTES;
		while (sb.bytes_in < random_goal) begin
			if ($urandom_range(0, 39) == 0)
				sender_gaps = !sender_gaps;
			send_random_piece();
		end

		// one long identifier at full rate, then an arrow, an integer and a lone equals
		drain_tokens();
		sender_gaps = 1'b0;
		send_byte(CH_NUL);
		for (int i = 0; i < LONG_IDENT_LEN; i++)
			send_byte(CH_LOWER_A + 8'(i % 26));
		for (int i = 6; i >= 0; i--)
			send_byte(TAIL[8 * i +: 8]);
		send_byte(CH_NUL);
		sender_gaps = 1'b1;

		// bad byte closes an identifier and halts; everything after is ignored
		send_byte(CH_LOWER_A);
		send_byte(CH_UPPER_A);
		send_byte(CH_BAD);
		send_byte(8'h80);
		send_byte(CH_LOWER_A);
		send_byte(CH_NUL);
		repeat (24) send_byte(8'($urandom_range(0, 255)));

		// collect what is left, then watch for strays
		ch_valid <= 1'b0;
		for (wait_cycles = 0; wait_cycles < DRAIN_LIMIT && sb.outstanding() != 0; wait_cycles++)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (sb.outstanding() != 0) begin
			$error("%0d tokens never arrived", sb.outstanding());
			sb.mismatches += sb.outstanding();
		end

		$display("Run: %0d source bytes accepted, %0d tokens checked, kinds seen %b",
			sb.bytes_in, sb.tokens_out, sb.kinds_seen);
		$display("Run: two-token bytes, sink backpressure, long identifier, halt on bad byte");
		if (sb.mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

[small_language_tokenizer_core.f]
hdl/slt_pkg.sv
hdl/slt_front.sv
hdl/slt_queue.sv
hdl/slt_back.sv
hdl/small_language_tokenizer_core.sv
tb/tb_small_language_tokenizer_core.sv
